>>> rtl/sstp_pkg.sv
// Package with the phase and status codes and widths of the storage size text parser.
`timescale 1ns / 1ps

package sstp_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned CountW   = 64;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ProgW    = 3;
  localparam int unsigned ShiftW   = 6;
  localparam int unsigned OutDataW = 72;

  localparam logic [1:0] PhStart  = 2'd0;
  localparam logic [1:0] PhMax    = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhSuffix = 2'd3;

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StMalformed = 2'd1;
  localparam logic [StatusW-1:0] StZero      = 2'd2;
  localparam logic [StatusW-1:0] StOverflow  = 2'd3;

  localparam logic [ProgW-1:0] ProgNone = 3'd0;
  localparam logic [ProgW-1:0] ProgOne  = 3'd1;
  localparam logic [ProgW-1:0] ProgTwo  = 3'd2;
  localparam logic [ProgW-1:0] ProgDone = 3'd3;

  localparam logic [ShiftW-1:0] ShiftB   = 6'd0;
  localparam logic [ShiftW-1:0] ShiftKiB = 6'd10;
  localparam logic [ShiftW-1:0] ShiftMiB = 6'd20;
  localparam logic [ShiftW-1:0] ShiftGiB = 6'd30;
  localparam logic [ShiftW-1:0] ShiftTiB = 6'd40;

endpackage

>>> rtl/storage_size_text_parser_top.sv
// Top level of the storage size text parser: byte stream in, one size result per string out.
`timescale 1ns / 1ps

// The slave channel takes one character of a size string per beat, with tlast on its
// final character. The string is the keyword max or decimal digits with an optional
// B, KiB, MiB, GiB or TiB suffix. For each string the master channel gives one beat
// carrying the 64-bit size in bytes and a 2-bit status (ok, malformed, zero count,
// overflow); characters other than the last produce no beat.
// A beat first lands in an input register. When it advances, the parse state is
// updated and, on the last character, the result is formed and written to the
// output register, from which it is offered on the master channel.
// One character is accepted every cycle unless the output stalls on a last character;
// the combinational count multiply-by-ten and add in the parse stage sets the rate.
// When the receiver stalls, the output register holds its beat; characters that do
// not end a string still advance, and the next last character waits in the input
// register, which in turn drops s_axis_tready.
// Reset clears both valid flags and returns the parser to the start of a string.
module storage_size_text_parser_top
  import sstp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] character
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [63:0] size_value, [65:64] status, zero pad
);

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_last_q;

  logic [CountW-1:0] count_q, count_d;
  logic [1:0]        phase_q, phase_d;
  logic [ProgW-1:0]  prog_q, prog_d;
  logic [ShiftW-1:0] shift_q, shift_d;
  logic              mal_q, mal_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q;
  logic [CountW-1:0] out_value_q, out_value_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic              out_free;
  logic              advance;
  logic              s_accept;
  logic              is_digit;
  logic [CountW+3:0] sum;
  logic              sum_ovf;
  logic [ProgW-1:0]  sfx_prog;
  logic              scale_ovf;
  logic [CountW-1:0] scaled;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign is_digit = (in_char_q >= 8'h30) && (in_char_q <= 8'h39);
  assign sum = ({4'b0, count_q} << 3) + ({4'b0, count_q} << 1)
             + {{(CountW){1'b0}}, in_char_q[3:0]};
  assign sum_ovf = |sum[CountW+3:CountW];
  assign sfx_prog = (phase_q == PhDigits) ? ProgNone : prog_q;

  // Parse step for the character in the input register.
  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    prog_d  = prog_q;
    shift_d = shift_q;
    mal_d   = mal_q;
    ovf_d   = ovf_q;
    if (!mal_q && !ovf_q) begin
      if ((phase_q == PhStart || phase_q == PhDigits) && is_digit) begin
        phase_d = PhDigits;
        if (sum_ovf) begin
          ovf_d = 1'b1;
        end else begin
          count_d = sum[CountW-1:0];
        end
      end else if (phase_q == PhStart) begin
        if (in_char_q == "m") begin
          phase_d = PhMax;
          prog_d  = ProgOne;
        end else begin
          mal_d = 1'b1;
        end
      end else if (phase_q == PhMax) begin
        if (prog_q == ProgOne && in_char_q == "a") begin
          prog_d = ProgTwo;
        end else if (prog_q == ProgTwo && in_char_q == "x") begin
          prog_d = ProgDone;
        end else begin
          mal_d = 1'b1;
        end
      end else begin
        phase_d = PhSuffix;
        prog_d  = sfx_prog;
        if (sfx_prog == ProgNone) begin
          unique case (in_char_q)
            "B": begin shift_d = ShiftB;   prog_d = ProgDone; end
            "K": begin shift_d = ShiftKiB; prog_d = ProgOne;  end
            "M": begin shift_d = ShiftMiB; prog_d = ProgOne;  end
            "G": begin shift_d = ShiftGiB; prog_d = ProgOne;  end
            "T": begin shift_d = ShiftTiB; prog_d = ProgOne;  end
            default: mal_d = 1'b1;
          endcase
        end else if (sfx_prog == ProgOne && in_char_q == "i") begin
          prog_d = ProgTwo;
        end else if (sfx_prog == ProgTwo && in_char_q == "B") begin
          prog_d = ProgDone;
        end else begin
          mal_d = 1'b1;
        end
      end
    end
  end

  // Scaling by the suffix; the shift takes only the suffix exponents.
  always_comb begin
    unique case (shift_d)
      ShiftKiB: begin
        scale_ovf = |count_d[CountW-1:CountW-10];
        scaled    = {count_d[CountW-11:0], 10'b0};
      end
      ShiftMiB: begin
        scale_ovf = |count_d[CountW-1:CountW-20];
        scaled    = {count_d[CountW-21:0], 20'b0};
      end
      ShiftGiB: begin
        scale_ovf = |count_d[CountW-1:CountW-30];
        scaled    = {count_d[CountW-31:0], 30'b0};
      end
      ShiftTiB: begin
        scale_ovf = |count_d[CountW-1:CountW-40];
        scaled    = {count_d[CountW-41:0], 40'b0};
      end
      default: begin
        scale_ovf = 1'b0;
        scaled    = count_d;
      end
    endcase
  end

  // Result for a string that ends with the current character.
  always_comb begin
    out_value_d  = '0;
    out_status_d = StOk;
    priority if (phase_d == PhStart) begin
      out_status_d = StMalformed;
    end else if (phase_d == PhMax) begin
      out_status_d = (!mal_d && prog_d == ProgDone) ? StOk : StMalformed;
    end else if (ovf_d) begin
      out_status_d = StOverflow;
    end else if (count_d == '0) begin
      out_status_d = StZero;
    end else if (mal_d || (phase_d == PhSuffix && prog_d != ProgDone)) begin
      out_status_d = StMalformed;
    end else if (scale_ovf) begin
      out_status_d = StOverflow;
    end else begin
      out_value_d = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      phase_q     <= PhStart;
      prog_q      <= ProgNone;
      shift_q     <= ShiftB;
      mal_q       <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (in_last_q) begin
          count_q <= '0;
          phase_q <= PhStart;
          prog_q  <= ProgNone;
          shift_q <= ShiftB;
          mal_q   <= 1'b0;
          ovf_q   <= 1'b0;
        end else begin
          count_q <= count_d;
          phase_q <= phase_d;
          prog_q  <= prog_d;
          shift_q <= shift_d;
          mal_q   <= mal_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - CountW - StatusW){1'b0}}, out_status_q, out_value_q};

endmodule
